/* design/tbde_pkg.sv */
// Shared types and constants for the three-button duration editor.
package tbde_pkg;

	localparam int unsigned SET_W    = 7;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned IDX_W    = 2;
	localparam int unsigned IN_W     = 8;
	localparam int unsigned OUT_W    = 48;

	localparam logic [SET_W-1:0]    WRAP_LIMIT     = 7'd99;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd50;
	localparam logic [SET_W-1:0]    RED_RESET      = 7'd5;
	localparam logic [SET_W-1:0]    YELLOW_RESET   = 7'd2;
	localparam logic [SET_W-1:0]    GREEN_RESET    = 7'd3;

	localparam logic [MODE_W-1:0] MODE_INIT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ONE    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RED    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_YELLOW = 3'd3;
	localparam logic [MODE_W-1:0] MODE_GREEN  = 3'd4;

	localparam logic [IDX_W-1:0] REG_REPEAT_PERIOD  = 2'd0;
	localparam logic [IDX_W-1:0] REG_INITIAL_RED    = 2'd1;
	localparam logic [IDX_W-1:0] REG_INITIAL_YELLOW = 2'd2;
	localparam logic [IDX_W-1:0] REG_INITIAL_GREEN  = 2'd3;

	typedef enum logic [1:0] {
		BTN_RELEASED = 2'd0,
		BTN_PRESSED  = 2'd1,
		BTN_LONG     = 2'd2
	} btn_state_t;

	typedef struct packed {
		logic act;
		logic long_held;
	} btn_status_t;

endpackage

/* design/tbde_button.sv */
// Button machine: released, pressed and long-held, with press detection.
module tbde_button (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 pressed,
	input  logic                 held,
	output tbde_pkg::btn_status_t status
);

	tbde_pkg::btn_state_t state_q;
	tbde_pkg::btn_state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tbde_pkg::BTN_RELEASED: begin
				if (pressed) state_nxt = tbde_pkg::BTN_PRESSED;
			end
			tbde_pkg::BTN_PRESSED: begin
				if (!pressed)  state_nxt = tbde_pkg::BTN_RELEASED;
				else if (held) state_nxt = tbde_pkg::BTN_LONG;
			end
			tbde_pkg::BTN_LONG: begin
				if (!held) state_nxt = tbde_pkg::BTN_RELEASED;
			end
			default: state_nxt = tbde_pkg::BTN_RELEASED;
		endcase
	end

	always_comb begin
		status.act       = (state_q == tbde_pkg::BTN_RELEASED) && pressed;
		status.long_held = (state_q == tbde_pkg::BTN_LONG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbde_pkg::BTN_RELEASED;
		end else if (en) begin
			state_q <= state_nxt;
		end
	end

endmodule

/* design/three_button_duration_editor.sv */
// Top level: mode, setting and duration editor driven by three button machines.
// A result is registered and shown in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the single result register frees when taken.
// All updates for a tick are one combinational pass from the stored state.
// Reset: mode init, buttons released, repeat count zero, period 50,
// settings and durations red 5, yellow 2, green 3.
module three_button_duration_editor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// mode_pressed, mode_long, inc_pressed, inc_long, set_pressed, set_long, zeros
	input  logic [tbde_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// mode_now, red/yellow/green_setting, red/yellow/green_duration, zeros
	output logic [tbde_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_we,
	input  logic [tbde_pkg::IDX_W-1:0]    cfg_index,
	input  logic [tbde_pkg::CFG_W-1:0]    cfg_data
);

	localparam int unsigned SW = tbde_pkg::SET_W;
	localparam int unsigned PW = tbde_pkg::PERIOD_W;
	localparam int unsigned MW = tbde_pkg::MODE_W;

	function automatic logic [SW-1:0] bump(input logic [SW-1:0] v);
		logic [SW-1:0] r;
		r = v + 1'b1;
		if (r >= tbde_pkg::WRAP_LIMIT) r = {{(SW-1){1'b0}}, 1'b1};
		return r;
	endfunction

	logic          accept;
	logic [PW-1:0] period_q;
	logic [PW-1:0] count_q, count_nxt, count_inc;
	logic [MW-1:0] mode_q, mode_nxt;
	logic [SW-1:0] red_edit_q, yellow_edit_q, green_edit_q;
	logic [SW-1:0] red_commit_q, yellow_commit_q, green_commit_q;
	logic [SW-1:0] red_edit_nxt, yellow_edit_nxt, green_edit_nxt;
	logic [SW-1:0] red_commit_nxt, yellow_commit_nxt, green_commit_nxt;
	logic          raise, fire;
	logic          out_valid_q;
	logic [tbde_pkg::OUT_W-1:0] result_q;
	logic [SW-1:0] cfg_v7;

	tbde_pkg::btn_status_t mode_st, inc_st, set_st;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;
	assign cfg_v7   = cfg_data[SW-1:0];

	tbde_button u_mode_btn (
		.clk(clk), .arst_n(arst_n), .en(accept),
		.pressed(s_tdata[0]), .held(s_tdata[1]), .status(mode_st)
	);
	tbde_button u_inc_btn (
		.clk(clk), .arst_n(arst_n), .en(accept),
		.pressed(s_tdata[2]), .held(s_tdata[3]), .status(inc_st)
	);
	tbde_button u_set_btn (
		.clk(clk), .arst_n(arst_n), .en(accept),
		.pressed(s_tdata[4]), .held(s_tdata[5]), .status(set_st)
	);

	always_comb begin
		mode_nxt = mode_q;
		if (mode_st.act) begin
			priority if (mode_q == tbde_pkg::MODE_INIT || mode_q == tbde_pkg::MODE_GREEN)
				mode_nxt = tbde_pkg::MODE_ONE;
			else if (mode_q >= tbde_pkg::MODE_ONE && mode_q <= tbde_pkg::MODE_YELLOW)
				mode_nxt = mode_q + 1'b1;
			else
				mode_nxt = mode_q;
		end
	end

	// auto-repeat: count restarts when the hold ends, but that tick still counts
	always_comb begin
		count_inc = (s_tdata[3] ? count_q : '0) + 1'b1;
		fire      = inc_st.long_held && (count_inc >= period_q);
		count_nxt = count_q;
		if (inc_st.long_held) count_nxt = fire ? '0 : count_inc;
		raise = inc_st.act || fire;
	end

	always_comb begin
		red_edit_nxt    = red_edit_q;
		yellow_edit_nxt = yellow_edit_q;
		green_edit_nxt  = green_edit_q;
		if (raise && mode_nxt == tbde_pkg::MODE_RED)    red_edit_nxt    = bump(red_edit_q);
		if (raise && mode_nxt == tbde_pkg::MODE_YELLOW) yellow_edit_nxt = bump(yellow_edit_q);
		if (raise && mode_nxt == tbde_pkg::MODE_GREEN)  green_edit_nxt  = bump(green_edit_q);
		red_commit_nxt    = red_commit_q;
		yellow_commit_nxt = yellow_commit_q;
		green_commit_nxt  = green_commit_q;
		if (set_st.act && mode_nxt == tbde_pkg::MODE_RED)    red_commit_nxt    = red_edit_nxt;
		if (set_st.act && mode_nxt == tbde_pkg::MODE_YELLOW) yellow_commit_nxt = yellow_edit_nxt;
		if (set_st.act && mode_nxt == tbde_pkg::MODE_GREEN)  green_commit_nxt  = green_edit_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q        <= tbde_pkg::PERIOD_RESET;
			count_q         <= '0;
			mode_q          <= tbde_pkg::MODE_INIT;
			red_edit_q      <= tbde_pkg::RED_RESET;
			yellow_edit_q   <= tbde_pkg::YELLOW_RESET;
			green_edit_q    <= tbde_pkg::GREEN_RESET;
			red_commit_q    <= tbde_pkg::RED_RESET;
			yellow_commit_q <= tbde_pkg::YELLOW_RESET;
			green_commit_q  <= tbde_pkg::GREEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbde_pkg::REG_REPEAT_PERIOD: period_q <= cfg_data[PW-1:0];
				tbde_pkg::REG_INITIAL_RED: begin
					red_edit_q   <= cfg_v7;
					red_commit_q <= cfg_v7;
				end
				tbde_pkg::REG_INITIAL_YELLOW: begin
					yellow_edit_q   <= cfg_v7;
					yellow_commit_q <= cfg_v7;
				end
				tbde_pkg::REG_INITIAL_GREEN: begin
					green_edit_q   <= cfg_v7;
					green_commit_q <= cfg_v7;
				end
				default: period_q <= period_q;
			endcase
		end else if (accept) begin
			count_q         <= count_nxt;
			mode_q          <= mode_nxt;
			red_edit_q      <= red_edit_nxt;
			yellow_edit_q   <= yellow_edit_nxt;
			green_edit_q    <= green_edit_nxt;
			red_commit_q    <= red_commit_nxt;
			yellow_commit_q <= yellow_commit_nxt;
			green_commit_q  <= green_commit_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= {3'b000, green_commit_nxt, yellow_commit_nxt, red_commit_nxt,
				green_edit_nxt, yellow_edit_nxt, red_edit_nxt, mode_nxt};
		end
	end

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= tbde_pkg::MODE_GREEN)
		else $error("mode out of range");

	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted request left no result");

	a_mode_leaves_init: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_we && mode_st.act) |=> (mode_q != tbde_pkg::MODE_INIT))
		else $error("mode press left init mode");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!accept && !cfg_we) |=> ($stable(mode_q) && $stable(count_q)
			&& $stable(red_edit_q) && $stable(green_commit_q)))
		else $error("state changed without request");

endmodule
